@@ rtl/tls_pkg.sv @@
// Shared constants and types for the text line statistics block.
package tls_pkg;

	localparam int COUNT_BITS_DEF = 40;	// default counter width
	localparam int OUT_BITS       = 40;	// width of the count fields on the result port
	localparam int FILES_BITS     = 32;	// width of the file counter

	localparam logic [7:0] LINE_FEED = 8'h0A;

	typedef enum logic {
		KIND_FILE = 1'b0,
		KIND_AGG  = 1'b1
	} record_kind_t;

endpackage

@@ rtl/tls_file_count.sv @@
// Per-file counters: bytes, lines, empty lines, line width min/max.
module tls_file_count
	import tls_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            data_byte,
	input  logic                  byte_valid,
	input  logic                  end_of_file,
	output logic [COUNT_BITS-1:0] nxt_bytes,
	output logic [COUNT_BITS-1:0] nxt_lines,
	output logic [COUNT_BITS-1:0] nxt_empty,
	output logic [COUNT_BITS-1:0] nxt_wmin,
	output logic [COUNT_BITS-1:0] nxt_wmax
);

	logic [COUNT_BITS-1:0] bytes_q, lines_q, empty_q, width_q, wmin_q, wmax_q;
	logic [COUNT_BITS-1:0] nxt_width;
	logic                  is_lf;
	logic                  line_inc;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	always_comb begin
		is_lf     = byte_valid && (data_byte == LINE_FEED);
		nxt_bytes = byte_valid ? sat_inc(bytes_q) : bytes_q;
		nxt_empty = (is_lf && (width_q == '0)) ? sat_inc(empty_q) : empty_q;
		nxt_wmin  = (is_lf && (width_q < wmin_q)) ? width_q : wmin_q;
		nxt_wmax  = (is_lf && (width_q > wmax_q)) ? width_q : wmax_q;
		if (is_lf) begin
			nxt_width = '0;
		end else if (byte_valid) begin
			nxt_width = sat_inc(width_q);
		end else begin
			nxt_width = width_q;
		end
		// a line feed closes a line; an open line at end of file also counts
		line_inc  = is_lf || (end_of_file && (nxt_width != '0));
		nxt_lines = line_inc ? sat_inc(lines_q) : lines_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			lines_q <= '0;
			empty_q <= '0;
			width_q <= '0;
			wmin_q  <= '1;
			wmax_q  <= '0;
		end else if (advance) begin
			if (end_of_file) begin
				bytes_q <= '0;
				lines_q <= '0;
				empty_q <= '0;
				width_q <= '0;
				wmin_q  <= '1;
				wmax_q  <= '0;
			end else begin
				bytes_q <= nxt_bytes;
				lines_q <= nxt_lines;
				empty_q <= nxt_empty;
				width_q <= nxt_width;
				wmin_q  <= nxt_wmin;
				wmax_q  <= nxt_wmax;
			end
		end
	end

endmodule

@@ rtl/tls_aggregate.sv @@
// Running totals and per-file min/max over all finished files.
module tls_aggregate
	import tls_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  update,
	input  logic [COUNT_BITS-1:0] f_bytes,
	input  logic [COUNT_BITS-1:0] f_lines,
	input  logic [COUNT_BITS-1:0] f_empty,
	output logic [COUNT_BITS-1:0] nxt_sum_bytes,
	output logic [COUNT_BITS-1:0] nxt_sum_lines,
	output logic [COUNT_BITS-1:0] nxt_sum_empty,
	output logic [COUNT_BITS-1:0] nxt_size_min,
	output logic [COUNT_BITS-1:0] nxt_size_max,
	output logic [COUNT_BITS-1:0] nxt_lines_min,
	output logic [COUNT_BITS-1:0] nxt_lines_max,
	output logic [FILES_BITS-1:0] nxt_files
);

	logic [COUNT_BITS-1:0] sum_bytes_q, sum_lines_q, sum_empty_q;
	logic [COUNT_BITS-1:0] size_min_q, size_max_q, lines_min_q, lines_max_q;
	logic [FILES_BITS-1:0] files_q;

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
		input logic [COUNT_BITS-1:0] b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
	endfunction

	always_comb begin
		nxt_sum_bytes = sat_add(sum_bytes_q, f_bytes);
		nxt_sum_lines = sat_add(sum_lines_q, f_lines);
		nxt_sum_empty = sat_add(sum_empty_q, f_empty);
		nxt_size_min  = (f_bytes < size_min_q)  ? f_bytes : size_min_q;
		nxt_size_max  = (f_bytes > size_max_q)  ? f_bytes : size_max_q;
		nxt_lines_min = (f_lines < lines_min_q) ? f_lines : lines_min_q;
		nxt_lines_max = (f_lines > lines_max_q) ? f_lines : lines_max_q;
		nxt_files     = (&files_q) ? files_q : files_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_bytes_q <= '0;
			sum_lines_q <= '0;
			sum_empty_q <= '0;
			size_min_q  <= '1;
			size_max_q  <= '0;
			lines_min_q <= '1;
			lines_max_q <= '0;
			files_q     <= '0;
		end else if (update) begin
			sum_bytes_q <= nxt_sum_bytes;
			sum_lines_q <= nxt_sum_lines;
			sum_empty_q <= nxt_sum_empty;
			size_min_q  <= nxt_size_min;
			size_max_q  <= nxt_size_max;
			lines_min_q <= nxt_lines_min;
			lines_max_q <= nxt_lines_max;
			files_q     <= nxt_files;
		end
	end

endmodule

@@ rtl/tls_out_stage.sv @@
// Result register: holds a file/aggregate record pair and presents it in two transactions.
module tls_out_stage
	import tls_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [OUT_BITS-1:0] f_bytes,
	input  logic [OUT_BITS-1:0] f_lines,
	input  logic [OUT_BITS-1:0] f_empty,
	input  logic [OUT_BITS-1:0] f_wmin,
	input  logic [OUT_BITS-1:0] f_wmax,
	input  logic [OUT_BITS-1:0] a_bytes,
	input  logic [OUT_BITS-1:0] a_lines,
	input  logic [OUT_BITS-1:0] a_empty,
	input  logic [OUT_BITS-1:0] a_size_min,
	input  logic [OUT_BITS-1:0] a_size_max,
	input  logic [OUT_BITS-1:0] a_lines_min,
	input  logic [OUT_BITS-1:0] a_lines_max,
	input  logic [FILES_BITS-1:0] a_files,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                record_kind,
	output logic                last_record,
	output logic [OUT_BITS-1:0] byte_total,
	output logic [OUT_BITS-1:0] line_total,
	output logic [OUT_BITS-1:0] empty_line_total,
	output logic [OUT_BITS-1:0] first_min,
	output logic [OUT_BITS-1:0] first_max,
	output logic [OUT_BITS-1:0] second_min,
	output logic [OUT_BITS-1:0] second_max,
	output logic [FILES_BITS-1:0] file_total
);

	logic         pair_valid_q;
	record_kind_t phase_q;
	logic [OUT_BITS-1:0] f_bytes_q, f_lines_q, f_empty_q, f_wmin_q, f_wmax_q;
	logic [OUT_BITS-1:0] a_bytes_q, a_lines_q, a_empty_q;
	logic [OUT_BITS-1:0] a_size_min_q, a_size_max_q, a_lines_min_q, a_lines_max_q;
	logic [FILES_BITS-1:0] a_files_q;
	logic         out_take;
	logic         is_agg;

	assign out_valid = pair_valid_q;
	assign out_take  = pair_valid_q && out_ready;
	assign is_agg    = (phase_q == KIND_AGG);
	assign free      = !pair_valid_q || (out_take && is_agg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid_q <= 1'b0;
			phase_q      <= KIND_FILE;
		end else if (load) begin
			pair_valid_q <= 1'b1;
			phase_q      <= KIND_FILE;
		end else if (out_take) begin
			if (is_agg) begin
				pair_valid_q <= 1'b0;
			end else begin
				phase_q <= KIND_AGG;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			f_bytes_q     <= f_bytes;
			f_lines_q     <= f_lines;
			f_empty_q     <= f_empty;
			f_wmin_q      <= f_wmin;
			f_wmax_q      <= f_wmax;
			a_bytes_q     <= a_bytes;
			a_lines_q     <= a_lines;
			a_empty_q     <= a_empty;
			a_size_min_q  <= a_size_min;
			a_size_max_q  <= a_size_max;
			a_lines_min_q <= a_lines_min;
			a_lines_max_q <= a_lines_max;
			a_files_q     <= a_files;
		end
	end

	always_comb begin
		record_kind = phase_q;
		last_record = is_agg;
		if (is_agg) begin
			byte_total       = a_bytes_q;
			line_total       = a_lines_q;
			empty_line_total = a_empty_q;
			first_min        = a_size_min_q;
			first_max        = a_size_max_q;
			second_min       = a_lines_min_q;
			second_max       = a_lines_max_q;
			file_total       = a_files_q;
		end else begin
			byte_total       = f_bytes_q;
			line_total       = f_lines_q;
			empty_line_total = f_empty_q;
			first_min        = f_wmin_q;
			first_max        = f_wmax_q;
			second_min       = '0;
			second_max       = '0;
			file_total       = '0;
		end
	end

endmodule

@@ rtl/text_line_statistics.sv @@
// Text line statistics: one byte per transaction in; a per-file record followed by an
// aggregate record out at each end of file. Timing: an input transaction is registered,
// then the per-file and aggregate counters are updated from that register, so one byte
// per clock is accepted while no end of file waits on the result register. An item marked
// end_of_file loads a record pair into the result register, which hands out the file
// record and then the aggregate record in two output transactions; a following end of file
// waits until the aggregate record of the previous pair has been taken, and bytes flow at
// one per cycle as long as the output side keeps up. The file record reaches the output
// once its end-of-file transaction has passed the input register and been loaded into
// the result register. Counters are COUNT_BITS wide and saturate at all ones; the file
// counter saturates at 2^32-1. Count fields on the output are 40 bits: narrower counters
// are zero extended, wider ones are truncated. An item with neither a byte nor an end mark
// is absorbed and changes nothing.
module text_line_statistics
	import tls_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  byte_valid,
	input  logic                  end_of_file,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  record_kind,
	output logic                  last_record,
	output logic [OUT_BITS-1:0]   byte_total,
	output logic [OUT_BITS-1:0]   line_total,
	output logic [OUT_BITS-1:0]   empty_line_total,
	output logic [OUT_BITS-1:0]   first_min,
	output logic [OUT_BITS-1:0]   first_max,
	output logic [OUT_BITS-1:0]   second_min,
	output logic [OUT_BITS-1:0]   second_max,
	output logic [FILES_BITS-1:0] file_total
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       byte_valid_s1;
	logic       eof_s1;

	logic advance;		// stage 1 item retires into the counters this cycle
	logic out_free;		// result register can take a new record pair
	logic in_take;

	logic [COUNT_BITS-1:0] f_bytes, f_lines, f_empty, f_wmin, f_wmax;
	logic [COUNT_BITS-1:0] a_bytes, a_lines, a_empty;
	logic [COUNT_BITS-1:0] a_size_min, a_size_max, a_lines_min, a_lines_max;
	logic [FILES_BITS-1:0] a_files;

	// non-final bytes never need the result register; only file ends wait on it
	assign advance  = valid_s1 && (!eof_s1 || out_free);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1       <= data_byte;
			byte_valid_s1 <= byte_valid;
			eof_s1        <= end_of_file;
		end
	end

	tls_file_count #(
		.COUNT_BITS(COUNT_BITS)
	) u_file (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.data_byte  (byte_s1),
		.byte_valid (byte_valid_s1),
		.end_of_file(eof_s1),
		.nxt_bytes  (f_bytes),
		.nxt_lines  (f_lines),
		.nxt_empty  (f_empty),
		.nxt_wmin   (f_wmin),
		.nxt_wmax   (f_wmax)
	);

	// aggregate folds in the finished file's final counts
	tls_aggregate #(
		.COUNT_BITS(COUNT_BITS)
	) u_agg (
		.clk          (clk),
		.arst_n       (arst_n),
		.update       (advance && eof_s1),
		.f_bytes      (f_bytes),
		.f_lines      (f_lines),
		.f_empty      (f_empty),
		.nxt_sum_bytes(a_bytes),
		.nxt_sum_lines(a_lines),
		.nxt_sum_empty(a_empty),
		.nxt_size_min (a_size_min),
		.nxt_size_max (a_size_max),
		.nxt_lines_min(a_lines_min),
		.nxt_lines_max(a_lines_max),
		.nxt_files    (a_files)
	);

	tls_out_stage u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (advance && eof_s1),
		.f_bytes         (OUT_BITS'(f_bytes)),
		.f_lines         (OUT_BITS'(f_lines)),
		.f_empty         (OUT_BITS'(f_empty)),
		.f_wmin          (OUT_BITS'(f_wmin)),
		.f_wmax          (OUT_BITS'(f_wmax)),
		.a_bytes         (OUT_BITS'(a_bytes)),
		.a_lines         (OUT_BITS'(a_lines)),
		.a_empty         (OUT_BITS'(a_empty)),
		.a_size_min      (OUT_BITS'(a_size_min)),
		.a_size_max      (OUT_BITS'(a_size_max)),
		.a_lines_min     (OUT_BITS'(a_lines_min)),
		.a_lines_max     (OUT_BITS'(a_lines_max)),
		.a_files         (a_files),
		.free            (out_free),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.record_kind     (record_kind),
		.last_record     (last_record),
		.byte_total      (byte_total),
		.line_total      (line_total),
		.empty_line_total(empty_line_total),
		.first_min       (first_min),
		.first_max       (first_max),
		.second_min      (second_min),
		.second_max      (second_max),
		.file_total      (file_total)
	);

endmodule

@@ test/text_line_statistics_tb.sv @@
// Self-checking testbench for text_line_statistics: byte stream in, file/aggregate records out.
`timescale 1ns / 100ps

module text_line_statistics_tb
	import tls_pkg::*;
();

	localparam int CB            = COUNT_BITS_DEF;
	localparam int NFIELDS       = 10;
	localparam int STALL_CYCLES  = 250;	// long receiver hold-off, fills the block
	localparam int SETTLE_CYCLES = 8;	// idle time after the last expected record has come out
	localparam int MAX_PRINTED   = 60;	// cap on mismatch lines, all are still counted
	localparam logic [CB-1:0] COUNT_FULL = '1;

	// One result record as the block presents it on its output port.
	typedef struct {
		record_kind_t           kind;
		logic                   last;
		logic [OUT_BITS-1:0]    bytes;
		logic [OUT_BITS-1:0]    lines;
		logic [OUT_BITS-1:0]    empties;
		logic [OUT_BITS-1:0]    fmin;
		logic [OUT_BITS-1:0]    fmax;
		logic [OUT_BITS-1:0]    smin;
		logic [OUT_BITS-1:0]    smax;
		logic [FILES_BITS-1:0]  files;
	} stats_rec_t;

	typedef logic [63:0] field_vec_t [NFIELDS];

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [7:0]             data_byte;
	logic                   byte_valid;
	logic                   end_of_file;
	logic                   out_valid;
	logic                   out_ready;
	logic                   record_kind;
	logic                   last_record;
	logic [OUT_BITS-1:0]    byte_total;
	logic [OUT_BITS-1:0]    line_total;
	logic [OUT_BITS-1:0]    empty_line_total;
	logic [OUT_BITS-1:0]    first_min;
	logic [OUT_BITS-1:0]    first_max;
	logic [OUT_BITS-1:0]    second_min;
	logic [OUT_BITS-1:0]    second_max;
	logic [FILES_BITS-1:0]  file_total;

	// Predictor state: per-file counters and the running totals across files.
	logic [CB-1:0]          f_bytes, f_lines, f_empty, line_width, w_min, w_max;
	logic [CB-1:0]          t_bytes, t_lines, t_empty;
	logic [CB-1:0]          sz_min, sz_max, ln_min, ln_max;
	logic [FILES_BITS-1:0]  n_files;

	stats_rec_t  pending_records [$];	// records predicted, not yet seen on the output
	field_vec_t  got_fields, want_fields;
	stats_rec_t  got_rec, want_rec;
	string       field_names [NFIELDS] = '{"record_kind", "last_record", "byte_total",
		"line_total", "empty_line_total", "first_min", "first_max", "second_min",
		"second_max", "file_total"};

	int          error_count = 0;
	int          item_count = 0;	// transactions that carry a byte or an end mark
	int          files_sent = 0;
	int          records_checked = 0;
	int          input_stall_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          stall_request = 0;
	int          stall_left = 0;

	text_line_statistics DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.byte_valid       (byte_valid),
		.end_of_file      (end_of_file),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.record_kind      (record_kind),
		.last_record      (last_record),
		.byte_total       (byte_total),
		.line_total       (line_total),
		.empty_line_total (empty_line_total),
		.first_min        (first_min),
		.first_max        (first_max),
		.second_min       (second_min),
		.second_max       (second_max),
		.file_total       (file_total)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1_000_000;
		$display("text_line_statistics_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [CB-1:0] sat_up(input logic [CB-1:0] v);
		return (v == COUNT_FULL) ? v : v + 1'b1;
	endfunction

	function automatic logic [CB-1:0] sat_sum(input logic [CB-1:0] a, input logic [CB-1:0] b);
		logic [CB:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CB] ? COUNT_FULL : s[CB-1:0];
	endfunction

	function automatic field_vec_t fields_of(input stats_rec_t r);
		field_vec_t v;
		v[0] = 64'(r.kind);
		v[1] = 64'(r.last);
		v[2] = 64'(r.bytes);
		v[3] = 64'(r.lines);
		v[4] = 64'(r.empties);
		v[5] = 64'(r.fmin);
		v[6] = 64'(r.fmax);
		v[7] = 64'(r.smin);
		v[8] = 64'(r.smax);
		v[9] = 64'(r.files);
		return v;
	endfunction

	task automatic clear_file_counts();
		f_bytes    = '0;
		f_lines    = '0;
		f_empty    = '0;
		line_width = '0;
		w_min      = COUNT_FULL;
		w_max      = '0;
	endtask

	task automatic clear_all_counts();
		clear_file_counts();
		t_bytes = '0;
		t_lines = '0;
		t_empty = '0;
		n_files = '0;
		sz_min  = COUNT_FULL;
		sz_max  = '0;
		ln_min  = COUNT_FULL;
		ln_max  = '0;
	endtask

	// Apply one accepted transaction; an end mark queues the file record and then
	// the aggregate record.
	task automatic tally_item(input logic [7:0] b, input logic bv, input logic eof);
		stats_rec_t r;
		if (bv) begin
			f_bytes = sat_up(f_bytes);
			if (b == LINE_FEED) begin
				if (line_width < w_min)
					w_min = line_width;
				if (line_width > w_max)
					w_max = line_width;
				f_lines = sat_up(f_lines);
				if (line_width == '0)
					f_empty = sat_up(f_empty);
				line_width = '0;
			end else begin
				line_width = sat_up(line_width);
			end
		end
		if (!eof)
			return;

		// unterminated last line counts as a line, but not toward width min/max
		if (line_width != '0)
			f_lines = sat_up(f_lines);

		r.kind    = KIND_FILE;
		r.last    = 1'b0;
		r.bytes   = OUT_BITS'(f_bytes);
		r.lines   = OUT_BITS'(f_lines);
		r.empties = OUT_BITS'(f_empty);
		r.fmin    = OUT_BITS'(w_min);
		r.fmax    = OUT_BITS'(w_max);
		r.smin    = '0;
		r.smax    = '0;
		r.files   = '0;
		pending_records.push_back(r);

		t_bytes = sat_sum(t_bytes, f_bytes);
		t_lines = sat_sum(t_lines, f_lines);
		t_empty = sat_sum(t_empty, f_empty);
		if (f_lines < ln_min)
			ln_min = f_lines;
		if (f_lines > ln_max)
			ln_max = f_lines;
		if (f_bytes < sz_min)
			sz_min = f_bytes;
		if (f_bytes > sz_max)
			sz_max = f_bytes;
		if (n_files != '1)
			n_files = n_files + 1'b1;

		r.kind    = KIND_AGG;
		r.last    = 1'b1;
		r.bytes   = OUT_BITS'(t_bytes);
		r.lines   = OUT_BITS'(t_lines);
		r.empties = OUT_BITS'(t_empty);
		r.fmin    = OUT_BITS'(sz_min);
		r.fmax    = OUT_BITS'(sz_max);
		r.smin    = OUT_BITS'(ln_min);
		r.smax    = OUT_BITS'(ln_max);
		r.files   = n_files;
		pending_records.push_back(r);

		clear_file_counts();
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_error(input string msg);
		if (error_count < MAX_PRINTED)
			$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Every output transaction is matched against the oldest predicted record.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_ready)
			input_stall_cycles++;
		if (arst_n && out_valid && out_ready) begin
			got_rec.kind    = record_kind_t'(record_kind);
			got_rec.last    = last_record;
			got_rec.bytes   = byte_total;
			got_rec.lines   = line_total;
			got_rec.empties = empty_line_total;
			got_rec.fmin    = first_min;
			got_rec.fmax    = first_max;
			got_rec.smin    = second_min;
			got_rec.smax    = second_max;
			got_rec.files   = file_total;
			if (pending_records.size() == 0) begin
				report_error("result transaction with no record expected");
			end else begin
				want_rec    = pending_records.pop_front();
				got_fields  = fields_of(got_rec);
				want_fields = fields_of(want_rec);
				for (int i = 0; i < NFIELDS; i++) begin
					if (got_fields[i] !== want_fields[i])
						report_error($sformatf("record %0d %s: got %0h, expected %0h",
							records_checked, field_names[i], got_fields[i],
							want_fields[i]));
				end
			end
			records_checked++;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random ready, plus a long hold-off on request
	// ------------------------------------------------------------------

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				stall_left    = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offer one transaction at the falling edge, hold it until accepted.
	task automatic send_item(input logic [7:0] b, input logic bv, input logic eof);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		data_byte   = b;
		byte_valid  = bv;
		end_of_file = eof;
		do
			@(posedge clk);
		while (!in_ready);
		tally_item(b, bv, eof);
		if (bv || eof)
			item_count++;
		if (eof)
			files_sent++;
	endtask

	// Sender goes quiet until every predicted record has come out.
	task automatic wait_for_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly printable text with frequent line feeds, some arbitrary bytes.
	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 18)
			return LINE_FEED;
		if (r < 28)
			return 8'($urandom_range(255));
		return 8'($urandom_range(8'h7E, 8'h20));
	endfunction

	// One file: random length (mostly short), end mark either on the last byte
	// or as a transaction of its own; stray empty transactions mixed in.
	task automatic send_random_file(input int max_len);
		int  len;
		bit  eof_alone;
		len       = ($urandom_range(9) == 0) ? $urandom_range(max_len) : $urandom_range(12);
		eof_alone = (len == 0) || $urandom_range(1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(14) == 0)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(pick_text_byte(), 1'b1, (i == len - 1) && !eof_alone);
		end
		if (eof_alone)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// Corner cases: ignored transaction, empty file, end mark on a line feed and
	// on a plain byte, runs of empty lines, bytes around the line feed code.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 30;
		send_item(8'hFF, 1'b0, 1'b0);	// neither byte nor end mark: ignored
		send_item(8'h00, 1'b0, 1'b1);	// empty file
		send_item(LINE_FEED, 1'b1, 1'b1);	// single empty line, end on the feed
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h41, 1'b1, 1'b1);	// unterminated final line
		send_item(LINE_FEED, 1'b1, 1'b0);
		send_item(LINE_FEED, 1'b1, 1'b0);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(LINE_FEED, 1'b1, 1'b0);
		send_item(8'h55, 1'b0, 1'b0);	// ignored mid-file
		send_item(8'hAA, 1'b0, 1'b1);	// end mark alone after a full line
		send_item(8'h0B, 1'b1, 1'b0);
		send_item(8'h09, 1'b1, 1'b0);
		send_item(8'h08, 1'b1, 1'b0);
		send_item(LINE_FEED, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(LINE_FEED, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b1);	// short last line, no feed
		send_item(8'h00, 1'b0, 1'b1);	// second empty file, aggregate minima stay at 0
		wait_for_results();
	endtask

	task automatic test_random_phase(input int s_pct, input int r_pct, input int n_items);
		int target;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		target        = item_count + n_items;
		while (item_count < target)
			send_random_file(60);
		wait_for_results();
	endtask

	// Receiver holds off while the sender keeps pushing short files, so the
	// block backs up and drops in_ready.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk);
		stall_request = 1'b1;
		for (int i = 0; i < 20; i++)
			send_random_file(3);
		wait_for_results();
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		data_byte   = '0;
		byte_valid  = 1'b0;
		end_of_file = 1'b0;
		clear_all_counts();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_phase(24, 76, 170);
		test_random_phase(76, 24, 170);
		test_random_phase(0, 0, 170);
		test_backpressure();

		$display("summary: %0d transactions in %0d files, %0d records checked, %0d mismatches",
			item_count, files_sent, records_checked, error_count);
		$display("summary: directed corners, three idle mixes, %0d input stall cycles",
			input_stall_cycles);
		if (error_count == 0)
			$display("text_line_statistics_tb: PASS");
		else
			$display("text_line_statistics_tb: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/tls_pkg.sv
rtl/tls_file_count.sv
rtl/tls_aggregate.sv
rtl/tls_out_stage.sv
rtl/text_line_statistics.sv
test/text_line_statistics_tb.sv
